/* design/anbx_pkg.sv */
// shared types and constants for the annex b nal unit splitter
`default_nettype none

package anbx_pkg;

    localparam int unsigned DATA_BYTE_W     = 8;
    localparam int unsigned UNIT_INDEX_W    = 32;
    localparam int unsigned UNIT_OFFSET_W   = 32;
    localparam int unsigned UNIT_LENGTH_W   = 24;
    localparam int unsigned REFERENCE_IDC_W = 2;
    localparam int unsigned UNIT_TYPE_W     = 5;
    localparam int unsigned M_TDATA_W       = 104;
    localparam int unsigned M_TDATA_PAD_W   = M_TDATA_W - (UNIT_INDEX_W + UNIT_OFFSET_W
                                              + UNIT_LENGTH_W + 1 + 1 + REFERENCE_IDC_W
                                              + UNIT_TYPE_W);

    // result queue holds enough items for two bytes that each make two results
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_ONE  = 8'h01;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_BODY = 3'b010,
        PH_ERR  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [UNIT_INDEX_W-1:0]    unit_index;
        logic [UNIT_OFFSET_W-1:0]   unit_offset;
        logic [UNIT_LENGTH_W-1:0]   unit_length;
        logic                       long_start_code;
        logic                       forbidden_flag;
        logic [REFERENCE_IDC_W-1:0] reference_idc;
        logic [UNIT_TYPE_W-1:0]     unit_type;
        logic                       stream_error;
        logic                       last_of_run;
    } result_t;

    // results made by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

/* design/annexb_nal_unit_splitter_top.sv */
// top level of the annex b nal unit splitter
`default_nettype none

// Splits an H.264 Annex B byte stream into NAL units. One stream byte is taken per
// clock (s_tlast marks the last byte of a stream) and the per-byte parser state is
// updated in that same cycle, so bytes are accepted back to back at one per cycle
// while s_tready is high. A result item is written into the result queue when the
// byte that causes it is accepted; a unit is reported when the next start code
// completes or at the end mark, and a start code on the last byte of a stream gives
// two items. Results wait in a four-item queue; s_tready drops only while that
// queue cannot take two more items, so with m_tready held high the input never
// stalls. A stream that does not open with 00 00 01 or 00 00 00 01 gives one item
// with m_tuser set and is then skipped up to its end mark. Lengths saturate at
// 2^LENGTH_BITS - 1 and are reported in 24 bits.
module annexb_nal_unit_splitter_top #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          s_tlast,   // end_of_stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // unit_index, unit_offset, unit_length, long_start_code, forbidden_flag,
    // reference_idc, unit_type, zero pad
    output logic [103:0]       m_tdata,
    output logic               m_tuser,   // stream_error
    output logic               m_tlast    // last_of_run
);
    import anbx_pkg::*;

    push_t   push;
    result_t out_item;
    logic    in_accept;

    assign in_accept = s_tvalid && s_tready;

    anbx_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .push          (push)
    );

    anbx_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {{M_TDATA_PAD_W{1'b0}}, out_item.unit_type, out_item.reference_idc,
                      out_item.forbidden_flag, out_item.long_start_code,
                      out_item.unit_length, out_item.unit_offset, out_item.unit_index};
    assign m_tuser = out_item.stream_error;
    assign m_tlast = out_item.last_of_run;

endmodule

`default_nettype wire

/* design/anbx_parser.sv */
// start code parser: per-byte state update and result building
`default_nettype none

module anbx_parser #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_accept,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_stream,
    output anbx_pkg::push_t                 push
);
    import anbx_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                   phase_reg,  phase_next;
    logic [23:0]              recent_reg, recent_next;
    logic [1:0]               lead_reg,   lead_next;
    logic [LENGTH_BITS-1:0]   body_reg,   body_next;
    logic [31:0]              pos_reg,    pos_next;
    logic [31:0]              offset_reg, offset_next;
    logic [31:0]              units_reg,  units_next;
    logic [7:0]               header_reg, header_next;
    logic                     long_reg,   long_next;

    logic                     is_code;
    logic                     is_long;
    logic                     bad;
    logic                     opened;
    logic [1:0]               extra;

    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] base,
                                                       input logic [1:0] add);
        logic [LENGTH_BITS:0] sum;
        begin
            sum = {1'b0, base} + (LENGTH_BITS+1)'(add);
            sat_add = sum[LENGTH_BITS] ? LEN_MAX : sum[LENGTH_BITS-1:0];
        end
    endfunction

    function automatic result_t unit_res(input logic [31:0] idx, input logic [31:0] off,
                                         input logic [LENGTH_BITS-1:0] len, input logic lng,
                                         input logic [7:0] hdr);
        result_t    r;
        logic [7:0] h;
        begin
            r = '0;
            // empty unit reports a zero header
            h = (len != '0) ? hdr : 8'h00;
            r.unit_index      = idx;
            r.unit_offset     = off;
            r.unit_length     = UNIT_LENGTH_W'(len);
            r.long_start_code = lng;
            r.forbidden_flag  = h[7];
            r.reference_idc   = h[6:5];
            r.unit_type       = h[4:0];
            unit_res = r;
        end
    endfunction

    function automatic result_t error_res();
        result_t r;
        begin
            r = '0;
            r.stream_error = 1'b1;
            error_res = r;
        end
    endfunction

    assign is_code = (data_byte == START_CODE_ONE) && (lead_reg >= 2'd2)
                     && (recent_reg[15:0] == 16'h0000);
    assign is_long = (lead_reg == 2'd3) && (recent_reg[23:16] == 8'h00);
    assign extra   = is_long ? 2'd0 : (lead_reg - 2'd2);

    always_comb begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        lead_next   = lead_reg;
        body_next   = body_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        units_next  = units_reg;
        header_next = header_reg;
        long_next   = long_reg;
        bad         = 1'b0;
        opened      = 1'b0;
        push        = '0;

        if (in_accept) begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_LEAD: begin
                    if (lead_reg < 2'd2) begin
                        if (data_byte == START_CODE_ZERO) lead_next = lead_reg + 2'd1;
                        else bad = 1'b1;
                    end else if (lead_reg == 2'd2) begin
                        if (data_byte == START_CODE_ONE) begin
                            opened      = 1'b1;
                            offset_next = pos_reg - 32'd2;
                            long_next   = 1'b0;
                        end else if (data_byte == START_CODE_ZERO) begin
                            lead_next = 2'd3;
                        end else begin
                            bad = 1'b1;
                        end
                    end else begin
                        if (data_byte == START_CODE_ONE) begin
                            opened      = 1'b1;
                            offset_next = pos_reg - 32'd3;
                            long_next   = 1'b1;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    if (opened) begin
                        phase_next  = PH_BODY;
                        lead_next   = 2'd0;
                        body_next   = '0;
                        recent_next = '0;
                        header_next = 8'h00;
                    end
                    if (bad) begin
                        push.count = 2'd1;
                        push.first = error_res();
                        phase_next = PH_ERR;
                    end else if (end_of_stream) begin
                        push.count = 2'd1;
                        push.first = opened ? unit_res(units_reg, offset_next, '0, long_next,
                                                       8'h00)
                                            : error_res();
                    end
                end
                PH_BODY: begin
                    if (is_code) begin
                        push.count  = 2'd1;
                        push.first  = unit_res(units_reg, offset_reg, sat_add(body_reg, extra),
                                               long_reg, header_reg);
                        units_next  = units_reg + 32'd1;
                        offset_next = pos_reg - (is_long ? 32'd3 : 32'd2);
                        long_next   = is_long;
                        lead_next   = 2'd0;
                        body_next   = '0;
                        recent_next = '0;
                        header_next = 8'h00;
                        if (end_of_stream) begin
                            push.count  = 2'd2;
                            push.second = unit_res(units_next, offset_next, '0, is_long, 8'h00);
                        end
                    end else begin
                        if ((body_reg == '0) && (lead_reg == 2'd0)) header_next = data_byte;
                        // oldest pending byte is committed once three are held back
                        if (lead_reg == 2'd3) body_next = sat_add(body_reg, 2'd1);
                        else lead_next = lead_reg + 2'd1;
                        recent_next = {recent_reg[15:0], data_byte};
                        if (end_of_stream) begin
                            push.count = 2'd1;
                            push.first = unit_res(units_reg, offset_reg,
                                                  sat_add(body_next, lead_next), long_reg,
                                                  header_next);
                        end
                    end
                end
                PH_ERR: begin
                    phase_next = PH_ERR;
                end
                default: begin
                    phase_next = PH_LEAD;
                end
            endcase

            if (push.count == 2'd1) push.first.last_of_run = 1'b1;
            if (push.count == 2'd2) push.second.last_of_run = 1'b1;

            // end of stream returns everything to the reset state
            if (end_of_stream) begin
                phase_next  = PH_LEAD;
                recent_next = '0;
                lead_next   = 2'd0;
                body_next   = '0;
                pos_next    = '0;
                offset_next = '0;
                units_next  = '0;
                header_next = 8'h00;
                long_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            recent_reg <= '0;
            lead_reg   <= 2'd0;
            body_reg   <= '0;
            pos_reg    <= '0;
            offset_reg <= '0;
            units_reg  <= '0;
            header_reg <= 8'h00;
            long_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            recent_reg <= recent_next;
            lead_reg   <= lead_next;
            body_reg   <= body_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            units_reg  <= units_next;
            header_reg <= header_next;
            long_reg   <= long_next;
        end
    end

endmodule

`default_nettype wire

/* design/anbx_result_queue.sv */
// small result queue taking up to two items per cycle and giving one
`default_nettype none

module anbx_result_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  anbx_pkg::push_t       push,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output anbx_pkg::result_t     out_item
);
    import anbx_pkg::*;

    result_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg,  count_next;
    logic                    pop;

    // room for two items is kept so a byte is never refused midway
    assign in_ready  = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2) mem[wr_ptr_reg + QUEUE_PTR_W'(1)] <= push.second;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH) - QUEUE_CNT_W'(push.count)))
        else $error("result queue overflow");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pop && (push.count == 2'd0)) |=> $stable(count_reg))
        else $error("queue count moved without push or pop");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd1) |-> push.first.last_of_run)
        else $error("single result without last mark");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
        else $error("result pair with wrong last marks");

endmodule

`default_nettype wire

/* test/annexb_unit_checker.sv */
// checker for the annex b nal unit splitter: predicts units from accepted bytes and compares
`default_nettype none

module annexb_unit_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         m_tlast,
    output int                fail_count,
    output int                pending,
    output int                results_checked,
    output int                error_results
);
    import anbx_pkg::*;

    localparam longint unsigned LEN_MAX = (64'd1 << UNIT_LENGTH_W) - 1;

    result_t unit_q[$];

    int n_fail    = 0;
    int n_pending = 0;
    int n_checked = 0;
    int n_errors  = 0;

    assign fail_count      = n_fail;
    assign pending         = n_pending;
    assign results_checked = n_checked;
    assign error_results   = n_errors;

    // parser state as the splitter should hold it
    phase_t      phase      = PH_LEAD;
    logic [23:0] recent     = '0;
    logic [2:0]  lead       = '0;
    logic [23:0] body       = '0;
    logic [31:0] position   = '0;
    logic [31:0] cur_offset = '0;
    logic [31:0] units      = '0;
    logic [7:0]  header     = '0;
    logic        cur_long   = 1'b0;

    function automatic logic [23:0] clip_len(input longint unsigned v);
        return (v > LEN_MAX) ? LEN_MAX[23:0] : v[23:0];
    endfunction

    task automatic clear_stream();
        phase      = PH_LEAD;
        recent     = '0;
        lead       = '0;
        body       = '0;
        position   = '0;
        cur_offset = '0;
        units      = '0;
        header     = '0;
        cur_long   = 1'b0;
    endtask

    task automatic open_unit(input logic [31:0] offset, input logic is_long);
        phase      = PH_BODY;
        cur_offset = offset;
        cur_long   = is_long;
        lead       = '0;
        body       = '0;
        recent     = '0;
        header     = '0;
    endtask

    function automatic result_t unit_result(input logic [23:0] len);
        result_t    r;
        logic [7:0] h;
        h = (len != '0) ? header : 8'h00;
        r = '0;
        r.unit_index      = units;
        r.unit_offset     = cur_offset;
        r.unit_length     = len;
        r.long_start_code = cur_long;
        r.forbidden_flag  = h[7];
        r.reference_idc   = h[6:5];
        r.unit_type       = h[4:0];
        return r;
    endfunction

    function automatic result_t error_result();
        result_t r;
        r = '0;
        r.stream_error = 1'b1;
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic eos);
        logic [31:0] p;
        logic        bad;
        logic        is_long;
        logic [2:0]  extra;
        result_t     outs [2];
        int          nres;
        p        = position;
        position = position + 32'd1;
        bad      = 1'b0;
        nres     = 0;
        case (phase)
            PH_LEAD: begin
                if (lead < 3'd2) begin
                    if (b == START_CODE_ZERO) lead = lead + 3'd1;
                    else bad = 1'b1;
                end else if (lead == 3'd2) begin
                    if (b == START_CODE_ONE) open_unit(p - 32'd2, 1'b0);
                    else if (b == START_CODE_ZERO) lead = 3'd3;
                    else bad = 1'b1;
                end else begin
                    if (b == START_CODE_ONE) open_unit(p - 32'd3, 1'b1);
                    else bad = 1'b1;
                end
                if (bad) begin
                    outs[0] = error_result();
                    nres    = 1;
                    phase   = PH_ERR;
                end else if (eos) begin
                    outs[0] = (phase == PH_BODY) ? unit_result('0) : error_result();
                    nres    = 1;
                end
            end
            PH_BODY: begin
                if (b == START_CODE_ONE && lead >= 3'd2 && recent[15:0] == 16'h0000) begin
                    is_long = (lead == 3'd3 && recent[23:16] == 8'h00);
                    extra   = is_long ? 3'd0 : lead - 3'd2;
                    outs[0] = unit_result(clip_len(longint'(body) + longint'(extra)));
                    nres    = 1;
                    units   = units + 32'd1;
                    open_unit(p - (is_long ? 32'd3 : 32'd2), is_long);
                    if (eos) begin
                        outs[1] = unit_result('0);
                        nres    = 2;
                    end
                end else begin
                    if (body == '0 && lead == 3'd0) header = b;
                    if (lead >= 3'd3) body = clip_len(longint'(body) + 1);
                    else lead = lead + 3'd1;
                    recent = {recent[15:0], b};
                    if (eos) begin
                        outs[0] = unit_result(clip_len(longint'(body) + longint'(lead)));
                        nres    = 1;
                    end
                end
            end
            default: ;
        endcase
        if (nres > 0) outs[nres-1].last_of_run = 1'b1;
        for (int i = 0; i < nres; i++) unit_q.push_back(outs[i]);
        if (eos) clear_stream();
    endtask

    task automatic report_mismatch(input string msg);
        if (n_fail < 40) $display("mismatch at result %0d: %s", n_checked, msg);
        n_fail++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (unit_q.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = unit_q.pop_front();
                    check_field("unit_index", m_tdata[31:0], want.unit_index);
                    check_field("unit_offset", m_tdata[63:32], want.unit_offset);
                    check_field("unit_length", m_tdata[87:64], want.unit_length);
                    check_field("long_start_code", m_tdata[88], want.long_start_code);
                    check_field("forbidden_flag", m_tdata[89], want.forbidden_flag);
                    check_field("reference_idc", m_tdata[91:90], want.reference_idc);
                    check_field("unit_type", m_tdata[96:92], want.unit_type);
                    check_field("stream_error", m_tuser, want.stream_error);
                    check_field("last_of_run", m_tlast, want.last_of_run);
                    if (want.stream_error) n_errors++;
                end
                n_checked++;
            end
            n_pending = unit_q.size();
        end
    end

endmodule

`default_nettype wire

/* test/annexb_nal_unit_splitter_top_tb.sv */
// stimulus and verdict for the annex b nal unit splitter
`default_nettype none

module annexb_nal_unit_splitter_top_tb;
    import anbx_pkg::*;

    localparam int TARGET_BYTES = 1650;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tready = 1'b0;
    wire  logic         s_tready;
    wire  logic         m_tvalid;
    wire  logic [103:0] m_tdata;
    wire  logic         m_tuser;
    wire  logic         m_tlast;

    int fails;
    int pending;
    int checked;
    int error_units;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int sent_bytes = 0;
    int streams    = 0;

    logic [7:0] stream_q[$];

    annexb_nal_unit_splitter_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    annexb_unit_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fails),
        .pending         (pending),
        .results_checked (checked),
        .error_results   (error_units)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #2_000_000;
        $display("[annexb_nal_unit_splitter_top] ERROR");
        $finish;
    end

    task automatic set_idling(input int sel);
        case (sel % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 6; stall_pct = 6; end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic counted);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (counted) sent_bytes++;
    endtask

    // bytes from index live_len on are skipped by the block after a bad opening
    task automatic send_stream(input int live_len);
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1, i < live_len);
        stream_q.delete();
        streams++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // zeros and ones are common so that start codes form inside payloads too
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return START_CODE_ZERO;
        if (r < 50) return START_CODE_ONE;
        if (r < 55) return 8'h03;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_unit();
        int len;
        if ($urandom_range(1)) stream_q.push_back(START_CODE_ZERO);
        stream_q.push_back(START_CODE_ZERO);
        stream_q.push_back(START_CODE_ZERO);
        stream_q.push_back(START_CODE_ONE);
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
        for (int i = 0; i < len; i++) stream_q.push_back(payload_byte());
    endtask

    task automatic random_stream();
        int kind;
        int zeros;
        logic [7:0] bad;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // broken opening, then a short ignored tail
            zeros = $urandom_range(3);
            for (int i = 0; i < zeros; i++) stream_q.push_back(START_CODE_ZERO);
            if (zeros >= 2) bad = 8'($urandom_range(255, 2));
            else bad = 8'($urandom_range(255, 1));
            stream_q.push_back(bad);
            repeat ($urandom_range(4)) stream_q.push_back(8'($urandom_range(255)));
            send_stream(zeros + 1);
        end else if (kind < 12) begin
            // stream that stops inside its opening start code
            repeat ($urandom_range(3, 1)) stream_q.push_back(START_CODE_ZERO);
            send_stream(stream_q.size());
        end else begin
            repeat ($urandom_range(5, 1)) add_unit();
            if ($urandom_range(6) == 0)
                repeat ($urandom_range(3, 1)) stream_q.push_back(START_CODE_ZERO);
            send_stream(stream_q.size());
        end
    endtask

    task automatic queue_bytes(input logic [7:0] bytes[]);
        foreach (bytes[i]) stream_q.push_back(bytes[i]);
        send_stream(stream_q.size());
    endtask

    initial begin
        int phase_sel;
        logic paused;
        phase_sel = 0;
        paused    = 1'b0;
        set_idling(0);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // bad opening with an ignored end byte, then an end mark before any start code
        queue_bytes('{8'h47, 8'h00});
        queue_bytes('{8'h00});
        // empty unit closed by the end mark on the start code
        queue_bytes('{8'h00, 8'h00, 8'h01});
        // forbidden bit set; start code completes on the last byte
        queue_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h01});
        // all header bits but forbidden set, four-byte code mid stream, trailing zero at end
        queue_bytes('{8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00});

        while (sent_bytes < TARGET_BYTES) begin
            if (sent_bytes / 200 != phase_sel) begin
                phase_sel = sent_bytes / 200;
                set_idling(phase_sel);
            end
            if (!paused && sent_bytes > TARGET_BYTES / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            random_stream();
        end

        hold_until_drained();
        repeat (20) @(negedge aclk);

        $display("sent %0d counted bytes in %0d streams with four idling mixes",
                 sent_bytes, streams);
        $display("checked %0d unit results, %0d of them stream errors", checked, error_units);
        if (fails == 0) begin
            $display("[annexb_nal_unit_splitter_top] OK");
        end else begin
            $display("[annexb_nal_unit_splitter_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/anbx_pkg.sv
design/anbx_parser.sv
design/anbx_result_queue.sv
design/annexb_nal_unit_splitter_top.sv
test/annexb_unit_checker.sv
test/annexb_nal_unit_splitter_top_tb.sv
